// ===== rtl/itoa_rdx_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_rdx_pkg
// Shared constants, state codes and character helpers for the radix
// integer-to-ASCII converter.
// ----------------------------------------------------------------------------
package itoa_rdx_pkg;

    // Width of the number taken in and converted
    localparam int VALUE_WIDTH = 32;
    // Bits of a division step counter (one step per value bit)
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    // Bits of a digit count (0 up to VALUE_WIDTH digits)
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    // Bits of an index into the digit buffer
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    // Digit buffer depth: radix 2 gives one digit per bit
    localparam int DIGIT_DEPTH = VALUE_WIDTH;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [RADIX_W-1:0] DIGIT_LIMIT = 6'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'd45;
    localparam logic [CHAR_W-1:0] CH_CR      = 7'd13;
    localparam logic [CHAR_W-1:0] CH_LF      = 7'd10;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_SIGN = 6'b000100,
        S_EMIT = 6'b001000,
        S_CR   = 6'b010000,
        S_LF   = 6'b100000
    } state_t;

    // Clamp a raw radix register to the usable range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d >= DIGIT_LIMIT)
            res = CH_LOWER_A + {1'b0, d} - {1'b0, DIGIT_LIMIT};
        else
            res = CH_ZERO + {1'b0, d};
        return res;
    endfunction

endpackage

// ===== rtl/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one number to ASCII digits in a configured radix, most
// significant digit first, with optional leading minus and trailing CR LF.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+---------------------------
//  command   | value, mode, append_newline            | start high, busy low
//  result    | char_out, last                         | char_valid, one cycle
//  config    | cfg_wdata                              | cfg_we, no wait
//
// One shared restoring divide step (compare and subtract against the radix)
// runs once per cycle; a digit costs one step of it per value bit.
// A number with D digits is divided digit by digit, then its characters go out
// one per cycle (sign, D digits, CR LF).
// busy stays high from acceptance until the last character is issued.
// Reset puts the sequencer idle and the radix to ten; the receiver cannot
// stall, so each character is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [itoa_rdx_pkg::RADIX_W-1:0]    cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [31:0]                         value,
    input  logic                                mode,
    input  logic                                append_newline,
    output logic                                char_valid,
    output logic [itoa_rdx_pkg::CHAR_W-1:0]     char_out,
    output logic                                last
);

    localparam int VW = itoa_rdx_pkg::VALUE_WIDTH;
    localparam int RW = itoa_rdx_pkg::RADIX_W;

    itoa_rdx_pkg::state_t state_reg, state_next;

    logic [RW-1:0]                       radix_reg, radix_next;
    logic [RW-1:0]                       rdx_reg, rdx_next;
    logic [VW-1:0]                       quo_reg, quo_next;
    logic [RW-1:0]                       rem_reg, rem_next;
    logic [itoa_rdx_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [itoa_rdx_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [itoa_rdx_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                                neg_reg, neg_next;
    logic                                nl_reg, nl_next;
    logic                                strobe_reg, strobe_next;
    logic [itoa_rdx_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                                last_reg, last_next;

    logic [RW-1:0] digit_mem [itoa_rdx_pkg::DIGIT_DEPTH];

    logic [VW-1:0] in_val;
    logic          in_neg;
    logic [VW-1:0] in_mag;
    logic [RW:0]   div_shift;
    logic          div_ge;
    logic [RW:0]   div_diff;
    logic [RW-1:0] div_rem;
    logic [VW-1:0] div_quo;
    logic          div_done;
    logic [RW-1:0] rd_digit_reg;

    // Take the sign off the incoming number
    assign in_val = value[VW-1:0];
    assign in_neg = mode & in_val[VW-1];
    assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

    // Shared restoring divide step: bring in one quotient bit per cycle
    assign div_shift = {rem_reg, quo_reg[VW-1]};
    assign div_ge    = (div_shift >= {1'b0, rdx_reg});
    assign div_diff  = div_shift - {1'b0, rdx_reg};
    assign div_rem   = div_ge ? div_diff[RW-1:0] : div_shift[RW-1:0];
    assign div_quo   = {quo_reg[VW-2:0], div_ge};
    assign div_done  = (state_reg == itoa_rdx_pkg::S_DIV)
                       && (step_reg == itoa_rdx_pkg::STEP_W'(VW - 1));

    // Sequencer and datapath next-state
    always_comb
    begin
        state_next  = state_reg;
        radix_next  = radix_reg;
        rdx_next    = rdx_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        nl_next     = nl_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;

        if (cfg_we)
            radix_next = cfg_wdata;

        case (state_reg)
            itoa_rdx_pkg::S_IDLE:
            begin
                if (start)
                begin
                    quo_next   = in_mag;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    neg_next   = in_neg;
                    nl_next    = append_newline;
                    rdx_next   = itoa_rdx_pkg::clamp_radix(radix_reg);
                    state_next = itoa_rdx_pkg::S_DIV;
                end
            end
            itoa_rdx_pkg::S_DIV:
            begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (div_done)
                begin
                    // Digit complete: store it, then divide again or print
                    cnt_next  = cnt_reg + 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    if (div_quo == '0)
                    begin
                        idx_next   = cnt_reg[itoa_rdx_pkg::IDX_W-1:0];
                        state_next = neg_reg ? itoa_rdx_pkg::S_SIGN : itoa_rdx_pkg::S_EMIT;
                    end
                end
            end
            itoa_rdx_pkg::S_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = itoa_rdx_pkg::CH_MINUS;
                state_next  = itoa_rdx_pkg::S_EMIT;
            end
            itoa_rdx_pkg::S_EMIT:
            begin
                // Walk the digit buffer from the most significant end
                strobe_next = 1'b1;
                char_next   = itoa_rdx_pkg::digit_char(rd_digit_reg);
                if (idx_reg == '0)
                begin
                    last_next  = ~nl_reg;
                    state_next = nl_reg ? itoa_rdx_pkg::S_CR : itoa_rdx_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            itoa_rdx_pkg::S_CR:
            begin
                strobe_next = 1'b1;
                char_next   = itoa_rdx_pkg::CH_CR;
                state_next  = itoa_rdx_pkg::S_LF;
            end
            itoa_rdx_pkg::S_LF:
            begin
                strobe_next = 1'b1;
                char_next   = itoa_rdx_pkg::CH_LF;
                last_next   = 1'b1;
                state_next  = itoa_rdx_pkg::S_IDLE;
            end
            default:
            begin
                state_next = itoa_rdx_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itoa_rdx_pkg::S_IDLE;
            radix_reg  <= itoa_rdx_pkg::RADIX_RESET;
            step_reg   <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            radix_reg  <= radix_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rdx_reg  <= rdx_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        nl_reg   <= nl_next;
        char_reg <= char_next;
    end

    // Hold remainders as digits, least significant first; read the digit
    // due next, forwarding the one being stored
    always_ff @(posedge clk)
    begin
        if (div_done)
            digit_mem[cnt_reg[itoa_rdx_pkg::IDX_W-1:0]] <= div_rem;
        if (div_done)
            rd_digit_reg <= div_rem;
        else
            rd_digit_reg <= digit_mem[idx_next];
    end

    assign busy       = (state_reg != itoa_rdx_pkg::S_IDLE);
    assign char_valid = strobe_reg;
    assign char_out   = char_reg;
    assign last       = last_reg;

endmodule
